/* sv/plpo_pkg.sv */
// Package for the leverage option payoff block: item types, control codes and
// the microprogram that sequences one item. Used by every module of the block.
`default_nettype none

package plpo_pkg;

    localparam int unsigned MAX_POINTS_DEF = 16;

    localparam int unsigned UPC_W = 5;
    localparam int unsigned DIV_BITS = 32;
    localparam int unsigned DIV_CNT_W = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic MODE_STAIRS = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_CALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_rate;
        logic signed [31:0] entry_factor;
        logic               entry_mode;
        logic [31:0]        spot;
        logic signed [31:0] eval_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] payoff;
        logic signed [31:0] notional;
        logic [3:0]         segment;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] rate;
        logic signed [31:0] factor;
        logic               mode;
    } t_entry;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_START,
        OP_CHK_LAST,
        OP_RD_MID,
        OP_BIS,
        OP_RD_LO,
        OP_RD_HI,
        OP_SEG,
        OP_MUL_LERP,
        OP_ROUND,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LERP_FIN,
        OP_INTR,
        OP_MUL_PAY,
        OP_PAY,
        OP_OUT,
        OP_LOAD
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_IF_LOAD,
        C_IF_GE_LAST,
        C_IF_DONE,
        C_IF_STAIRS,
        C_IF_MORE,
        C_WAIT_OUT
    } t_ucond;

    typedef struct packed {
        t_uop             op;
        t_ucond           cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic is_load;
        logic ge_last;
        logic srch_done;
        logic stairs;
        logic div_more;
        logic out_free;
    } t_dp_stat;

    localparam logic [UPC_W-1:0] U_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] U_START    = 5'd1;
    localparam logic [UPC_W-1:0] U_CHK_LAST = 5'd2;
    localparam logic [UPC_W-1:0] U_RD_MID   = 5'd3;
    localparam logic [UPC_W-1:0] U_BIS      = 5'd4;
    localparam logic [UPC_W-1:0] U_RD_LO    = 5'd5;
    localparam logic [UPC_W-1:0] U_RD_HI    = 5'd6;
    localparam logic [UPC_W-1:0] U_SEG      = 5'd7;
    localparam logic [UPC_W-1:0] U_MUL_LERP = 5'd8;
    localparam logic [UPC_W-1:0] U_ROUND    = 5'd9;
    localparam logic [UPC_W-1:0] U_DIV_INIT = 5'd10;
    localparam logic [UPC_W-1:0] U_DIV_STEP = 5'd11;
    localparam logic [UPC_W-1:0] U_LERP_FIN = 5'd12;
    localparam logic [UPC_W-1:0] U_INTR     = 5'd13;
    localparam logic [UPC_W-1:0] U_MUL_PAY  = 5'd14;
    localparam logic [UPC_W-1:0] U_PAY      = 5'd15;
    localparam logic [UPC_W-1:0] U_OUT      = 5'd16;
    localparam logic [UPC_W-1:0] U_LOAD     = 5'd17;
    localparam logic [UPC_W-1:0] U_LAST     = U_LOAD;

    // Control store: one word per step, a jump is taken when its condition holds.
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            U_IDLE:     w = '{op: OP_NOP,      cond: C_WAIT_IN,    target: U_IDLE};
            U_START:    w = '{op: OP_START,    cond: C_IF_LOAD,    target: U_LOAD};
            U_CHK_LAST: w = '{op: OP_CHK_LAST, cond: C_IF_GE_LAST, target: U_INTR};
            U_RD_MID:   w = '{op: OP_RD_MID,   cond: C_IF_DONE,    target: U_RD_LO};
            U_BIS:      w = '{op: OP_BIS,      cond: C_GOTO,       target: U_RD_MID};
            U_RD_LO:    w = '{op: OP_RD_LO,    cond: C_NEXT,       target: U_IDLE};
            U_RD_HI:    w = '{op: OP_RD_HI,    cond: C_NEXT,       target: U_IDLE};
            U_SEG:      w = '{op: OP_SEG,      cond: C_IF_STAIRS,  target: U_INTR};
            U_MUL_LERP: w = '{op: OP_MUL_LERP, cond: C_NEXT,       target: U_IDLE};
            U_ROUND:    w = '{op: OP_ROUND,    cond: C_NEXT,       target: U_IDLE};
            U_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,       target: U_IDLE};
            U_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_IF_MORE,    target: U_DIV_STEP};
            U_LERP_FIN: w = '{op: OP_LERP_FIN, cond: C_NEXT,       target: U_IDLE};
            U_INTR:     w = '{op: OP_INTR,     cond: C_NEXT,       target: U_IDLE};
            U_MUL_PAY:  w = '{op: OP_MUL_PAY,  cond: C_NEXT,       target: U_IDLE};
            U_PAY:      w = '{op: OP_PAY,      cond: C_NEXT,       target: U_IDLE};
            U_OUT:      w = '{op: OP_OUT,      cond: C_WAIT_OUT,   target: U_IDLE};
            U_LOAD:     w = '{op: OP_LOAD,     cond: C_GOTO,       target: U_OUT};
            default:    w = '{op: OP_NOP,      cond: C_GOTO,       target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/piecewise_leverage_option_payoff.sv */
// Top level of the rate-linked leverage option payoff block.
// Instantiates plpo_seq and plpo_dp; types and codes come from plpo_pkg.
//
// Usage: items enter on i_in_valid/o_in_ready. A load item writes one breakpoint
// entry and returns an all-zero result; an evaluate item returns payoff, notional
// and the chosen segment. Exactly one result leaves on o_out_valid/i_out_ready
// for every item, in order. Configuration writes use i_cfg_we, i_cfg_index and
// i_cfg_wdata and take effect at once; the user must make them only while the
// block is idle, as the block itself does not enforce it.
// Sequencing: one item is worked at a time by a microprogram. A load runs the
// start, load and result steps. An evaluate checks the last breakpoint; below
// it, bisection probes, reads of the segment ends and, for a linear segment, a
// multiply, rounding and a divider that retires one quotient bit per cycle over
// 32 steps follow. Every evaluate ends with intrinsic value, payoff and result.
// The block takes the next item once the result is registered.
// When the receiver stalls, the result waits in the output register, and the
// block still accepts and works the next item until it needs that register.
// Reset clears the handshakes and the configuration registers (strike 0, call,
// one point in use); the breakpoint memory is not cleared and must be loaded.
`default_nettype none

module piecewise_leverage_option_payoff #(
    parameter int unsigned MAX_POINTS = plpo_pkg::MAX_POINTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [plpo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [plpo_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire plpo_pkg::t_in_item              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output plpo_pkg::t_out_item                  o_out
);
    import plpo_pkg::*;

    t_uword   uword;
    t_dp_stat stat;
    logic     in_ready;
    logic     accept;

    assign accept     = i_in_valid && in_ready;
    assign o_in_ready = in_ready;

    plpo_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_stat     (stat),
        .o_uword    (uword),
        .o_in_ready (in_ready)
    );

    plpo_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_uword     (uword),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* sv/plpo_seq.sv */
// Microsequencer of the leverage option payoff block: step counter, control store
// lookup and conditional jumps on datapath status. Depends on plpo_pkg.
`default_nettype none

module plpo_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire plpo_pkg::t_dp_stat i_stat,
    output plpo_pkg::t_uword       o_uword,
    output logic                   o_in_ready
);
    import plpo_pkg::*;

    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    logic [UPC_W-1:0] pc_inc;
    t_uword           uw;

    assign uw = ucode(r_pc);
    assign pc_inc = r_pc + 1'b1;
    assign o_uword = uw;
    assign o_in_ready = (r_pc == U_IDLE);

    always_comb begin
        unique case (uw.cond)
            C_NEXT:       n_pc = pc_inc;
            C_GOTO:       n_pc = uw.target;
            C_WAIT_IN:    n_pc = i_accept ? U_START : r_pc;
            C_IF_LOAD:    n_pc = i_stat.is_load ? uw.target : pc_inc;
            C_IF_GE_LAST: n_pc = i_stat.ge_last ? uw.target : pc_inc;
            C_IF_DONE:    n_pc = i_stat.srch_done ? uw.target : pc_inc;
            C_IF_STAIRS:  n_pc = i_stat.stairs ? uw.target : pc_inc;
            C_IF_MORE:    n_pc = i_stat.div_more ? uw.target : pc_inc;
            C_WAIT_OUT:   n_pc = i_stat.out_free ? uw.target : r_pc;
            default:      n_pc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= U_LAST)
        else $error("step counter left the program");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_pc == U_START)
        else $error("accepted item did not start the program");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == U_OUT && !i_stat.out_free) |=> r_pc == U_OUT)
        else $error("result step left while output register was busy");
`endif

endmodule

`default_nettype wire

/* sv/plpo_dp.sv */
// Datapath of the leverage option payoff block: breakpoint memory, bisection
// bounds, shared multiplier, one-bit-per-step divider and the result register.
// Depends on plpo_pkg; driven by control words from plpo_seq.
`default_nettype none

module plpo_dp #(
    parameter int unsigned MAX_POINTS = plpo_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [plpo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [plpo_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          i_accept,
    input  wire plpo_pkg::t_in_item            i_in,
    input  wire plpo_pkg::t_uword              i_uword,
    output plpo_pkg::t_dp_stat                 o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output plpo_pkg::t_out_item                o_out
);
    import plpo_pkg::*;

    localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [31:0] r_strike;
    logic        r_is_call;
    logic [4:0]  r_points;

    t_in_item    r_item;
    t_entry      r_tab [MAX_POINTS];
    t_entry      r_rd;

    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic [IDX_W-1:0] r_seg;

    logic signed [31:0] r_r0;
    logic signed [31:0] r_f0;
    logic               r_mode0;
    logic [31:0]        r_d;
    logic [31:0]        r_u;
    logic [31:0]        r_mag;
    logic               r_dneg;
    logic [63:0]        r_prod;
    logic [31:0]        r_rem;
    logic [31:0]        r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic signed [31:0] r_note;
    logic [31:0]        r_intr;
    logic [31:0]        r_abs;
    logic               r_nneg;
    logic [63:0]        r_pay;

    t_out_item          r_out;
    logic               r_out_valid;

    logic [31:0]        n_pts;
    logic [IDX_W-1:0]   last_c;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid_c;
    logic [IDX_W:0]     span_c;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W+3:0]   wr_ext;
    logic [IDX_W+3:0]   seg_ext;
    logic               wr_ok;
    t_entry             wr_entry;
    logic signed [32:0] d_c;
    logic signed [32:0] u_c;
    logic signed [32:0] delta_c;
    logic signed [32:0] mag_c;
    logic [31:0]        uclamp_c;
    logic               lin_c;
    logic [32:0]        rem2_c;
    logic [32:0]        rem_sub_c;
    logic               q_bit_c;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_c;
    logic               out_free;

    // Clamp the configured point count into 1..MAX_POINTS.
    always_comb begin
        if (r_points == 5'd0) begin
            n_pts = 32'd1;
        end else if ({27'd0, r_points} > 32'(MAX_POINTS)) begin
            n_pts = 32'(MAX_POINTS);
        end else begin
            n_pts = {27'd0, r_points};
        end
        last_c = IDX_W'(n_pts - 32'd1);
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c   = mid_sum[IDX_W:1];
    assign span_c  = {1'b0, r_hi} - {1'b0, r_lo};

    always_comb begin
        unique case (i_uword.op)
            OP_START:  rd_addr = last_c;
            OP_RD_MID: rd_addr = mid_c;
            OP_RD_HI:  rd_addr = r_hi;
            default:   rd_addr = r_lo;
        endcase
    end

    assign wr_ext  = {{IDX_W{1'b0}}, r_item.entry_index};
    assign wr_ok   = {28'd0, r_item.entry_index} < 32'(MAX_POINTS);
    assign seg_ext = {4'd0, r_seg};

    always_comb begin
        wr_entry.rate   = r_item.entry_rate;
        wr_entry.factor = r_item.entry_factor;
        wr_entry.mode   = r_item.entry_mode;
    end

    // Segment geometry, valid while the upper breakpoint sits in r_rd.
    always_comb begin
        d_c     = {r_rd.rate[31], r_rd.rate} - {r_r0[31], r_r0};
        u_c     = {r_item.eval_rate[31], r_item.eval_rate} - {r_r0[31], r_r0};
        delta_c = {r_rd.factor[31], r_rd.factor} - {r_f0[31], r_f0};
        mag_c   = delta_c[32] ? -delta_c : delta_c;
        if (u_c < 0) begin
            uclamp_c = 32'd0;
        end else if (u_c > d_c) begin
            uclamp_c = d_c[31:0];
        end else begin
            uclamp_c = u_c[31:0];
        end
        lin_c = (r_mode0 == MODE_LINEAR) && (r_lo != r_last) && (d_c > 0);
    end

    assign rem2_c    = {r_rem, r_prod[63]};
    assign rem_sub_c = rem2_c - {1'b0, r_d};
    assign q_bit_c   = rem2_c >= {1'b0, r_d};

    assign mul_a = (i_uword.op == OP_MUL_PAY) ? r_intr : r_mag;
    assign mul_b = (i_uword.op == OP_MUL_PAY) ? r_abs : r_u;
    assign mul_c = {32'd0, mul_a} * {32'd0, mul_b};

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.is_load   = (r_item.cmd == CMD_LOAD);
        o_stat.ge_last   = $signed(r_item.eval_rate) >= $signed(r_rd.rate);
        o_stat.srch_done = span_c < (IDX_W+1)'(2);
        o_stat.stairs    = !lin_c;
        o_stat.div_more  = r_cnt != DIV_CNT_W'(1);
        o_stat.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike  <= 32'd0;
            r_is_call <= 1'b1;
            r_points  <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRIKE:  r_strike  <= i_cfg_wdata;
                CFG_IS_CALL: r_is_call <= i_cfg_wdata[0];
                CFG_POINTS:  r_points  <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.op == OP_LOAD && wr_ok) begin
            r_tab[wr_ext[IDX_W-1:0]] <= wr_entry;
        end
        r_rd <= r_tab[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_in;
        end
        unique case (i_uword.op)
            OP_START: begin
                r_last <= last_c;
                r_lo   <= '0;
                r_hi   <= last_c;
            end
            OP_CHK_LAST: begin
                r_seg  <= r_last;
                r_note <= r_rd.factor;
            end
            OP_RD_MID: r_mid <= mid_c;
            OP_BIS: begin
                if ($signed(r_item.eval_rate) < $signed(r_rd.rate)) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid;
                end
            end
            OP_RD_HI: begin
                r_r0    <= r_rd.rate;
                r_f0    <= r_rd.factor;
                r_mode0 <= r_rd.mode;
                r_seg   <= r_lo;
                r_note  <= r_rd.factor;
            end
            OP_SEG: begin
                r_d    <= d_c[31:0];
                r_u    <= uclamp_c;
                r_mag  <= mag_c[31:0];
                r_dneg <= delta_c[32];
            end
            OP_MUL_LERP: r_prod <= mul_c;
            OP_ROUND:    r_prod <= r_prod + {33'd0, r_d[31:1]};
            OP_DIV_INIT: begin
                r_rem  <= r_prod[63:32];
                r_prod <= {r_prod[31:0], 32'd0};
                r_quo  <= 32'd0;
                r_cnt  <= DIV_CNT_W'(DIV_BITS);
            end
            OP_DIV_STEP: begin
                r_rem  <= q_bit_c ? rem_sub_c[31:0] : rem2_c[31:0];
                r_quo  <= {r_quo[30:0], q_bit_c};
                r_prod <= {r_prod[62:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
            end
            OP_LERP_FIN: r_note <= r_dneg ? r_f0 - $signed(r_quo) : r_f0 + $signed(r_quo);
            OP_INTR: begin
                if (r_is_call) begin
                    r_intr <= (r_item.spot > r_strike) ? r_item.spot - r_strike : 32'd0;
                end else begin
                    r_intr <= (r_strike > r_item.spot) ? r_strike - r_item.spot : 32'd0;
                end
                r_abs  <= r_note[31] ? (~r_note) + 32'd1 : r_note;
                r_nneg <= r_note[31];
            end
            OP_MUL_PAY: r_prod <= mul_c;
            OP_PAY:     r_pay  <= r_nneg ? 64'd0 - r_prod : r_prod;
            OP_LOAD: begin
                r_pay  <= 64'd0;
                r_note <= 32'sd0;
                r_seg  <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.op == OP_OUT && out_free) begin
            r_out.payoff   <= r_pay;
            r_out.notional <= r_note;
            r_out.segment  <= seg_ext[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uword.op == OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_DIV_STEP) |-> r_rem < r_d)
        else $error("divider remainder not below divisor");
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.op == OP_BIS) |-> (r_lo < r_mid && r_mid < r_hi))
        else $error("bisection probe outside its bounds");
    a_out_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* bench/piecewise_leverage_option_payoff_tb.sv */
// Self-checking bench for piecewise_leverage_option_payoff: directed and random load and
// evaluate items, a built-in payoff predictor and an in-order result checker.
// Depends on plpo_pkg and the block's RTL.

module piecewise_leverage_option_payoff_tb;
    import plpo_pkg::*;

    localparam int unsigned NPTS = MAX_POINTS_DEF;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned NUM_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;

    longint      bp_rate [NPTS];
    longint      bp_factor [NPTS];
    bit          bp_mode [NPTS];
    longint      gen_rate [NPTS];
    logic [31:0] cfg_strike = '0;
    logic        cfg_call = 1'b1;
    logic [4:0]  cfg_points = 5'd1;

    t_in_item    pending_orders [$];
    t_out_item   awaited_payoffs [$];
    t_out_item   want;
    bit          in_fire, out_fire, in_busy;
    bit          idle_on = 1'b1;
    int unsigned send_gap, stall_left, hold_requests, hold_served;
    int unsigned quiet_cycles, mismatches, results_seen;

    piecewise_leverage_option_payoff i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial forever #1 i_clk = ~i_clk;

    function automatic longint lerp_notional(int unsigned seg, longint r);
        longint          span, delta, f0;
        longint unsigned offs, mag, q;
        f0 = bp_factor[seg];
        span = bp_rate[seg + 1] - bp_rate[seg];
        if (span <= 0) return f0;
        if (r < bp_rate[seg]) offs = 0;
        else if (r - bp_rate[seg] > span) offs = span;
        else offs = r - bp_rate[seg];
        delta = bp_factor[seg + 1] - f0;
        mag = (delta < 0) ? -delta : delta;
        q = (mag * offs + span / 2) / span;
        return (delta < 0) ? f0 - longint'(q) : f0 + longint'(q);
    endfunction

    function automatic t_out_item payoff_for(t_in_item it);
        t_out_item       res;
        int unsigned     n, lo, hi, mid, seg;
        longint          r, note;
        longint unsigned intr, abs_note, mag;
        res = '0;
        if (it.cmd == CMD_LOAD) begin
            bp_rate[it.entry_index] = longint'($signed(it.entry_rate));
            bp_factor[it.entry_index] = longint'($signed(it.entry_factor));
            bp_mode[it.entry_index] = it.entry_mode;
            return res;
        end
        n = 32'(cfg_points);
        if (n < 1) n = 1;
        if (n > NPTS) n = NPTS;
        r = longint'($signed(it.eval_rate));
        if (r >= bp_rate[n - 1]) begin
            seg = n - 1;
            note = bp_factor[seg];
        end else begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (r < bp_rate[mid]) hi = mid;
                else lo = mid;
            end
            seg = lo;
            if (bp_mode[seg] == MODE_STAIRS || seg + 1 >= n) note = bp_factor[seg];
            else note = lerp_notional(seg, r);
        end
        if (cfg_call) intr = (it.spot > cfg_strike) ? 64'(it.spot - cfg_strike) : 64'd0;
        else intr = (cfg_strike > it.spot) ? 64'(cfg_strike - it.spot) : 64'd0;
        abs_note = (note < 0) ? -note : note;
        mag = intr * abs_note;
        res.payoff = (note < 0) ? -mag : mag;
        res.notional = note[31:0];
        res.segment = seg[3:0];
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 12);
    endfunction

    function automatic logic [31:0] pick_factor();
        case ($urandom_range(7))
            0, 1, 2: return $urandom;
            3, 4: return $urandom_range(32'h0010_0000);
            5: return -$urandom_range(32'h0010_0000);
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        int unsigned k;
        longint      lo, hi;
        k = $urandom_range(NPTS - 1);
        lo = gen_rate[k];
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                if (k + 1 < NPTS && gen_rate[k + 1] > lo) begin
                    hi = gen_rate[k + 1];
                    return 32'(lo + ({$urandom, $urandom} % (hi - lo)));
                end
                return 32'(lo);
            end
            5, 6: return 32'(lo);
            7: return 32'(gen_rate[0] - $urandom_range(1000, 1));
            8: return 32'(gen_rate[NPTS - 1] + $urandom_range(1000, 0));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_spot();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4, 5: return cfg_strike + $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_load(int unsigned idx, logic [31:0] rate, logic [31:0] factor,
                              logic mode);
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.entry_index = idx[3:0];
        it.entry_rate = rate;
        it.entry_factor = factor;
        it.entry_mode = mode;
        it.spot = $urandom;
        it.eval_rate = $urandom;
        gen_rate[idx] = longint'($signed(rate));
        pending_orders.push_back(it);
    endtask

    task automatic queue_eval(logic [31:0] spot, logic [31:0] rate);
        t_in_item it;
        it = '0;
        it.cmd = CMD_EVAL;
        it.entry_index = 4'($urandom);
        it.entry_rate = $urandom;
        it.entry_factor = $urandom;
        it.entry_mode = 1'($urandom);
        it.spot = spot;
        it.eval_rate = rate;
        pending_orders.push_back(it);
    endtask

    task automatic queue_sorted_table();
        longint r;
        r = 0;
        for (int i = 0; i < NPTS; i++) begin
            queue_load(i, r[31:0], pick_factor(), 1'($urandom_range(1)));
            r += longint'(($urandom_range(4) == 0) ? $urandom_range(3)
                                                   : $urandom_range(32'h0800_0000, 1));
        end
    endtask

    task automatic wait_drained();
        while (pending_orders.size() != 0 || in_busy || awaited_payoffs.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_STRIKE: cfg_strike = val;
            CFG_IS_CALL: cfg_call = val[0];
            CFG_POINTS: cfg_points = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (in_busy && in_fire) in_busy = 1'b0;
        if (i_rst_n && !in_busy) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_orders.size() > 0) begin
                i_in <= pending_orders.pop_front();
                in_busy = 1'b1;
                send_gap = idle_on ? draw_gap() : 0;
            end
        end
        i_in_valid <= in_busy;
    end

    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) stall_left--;
        else if (idle_on && $urandom_range(99) < 20) stall_left = draw_gap() + 1;
        i_out_ready <= i_rst_n && stall_left == 0;
    end

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (out_fire) begin
            results_seen++;
            if (awaited_payoffs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: payoff %h notional %h segment %0d",
                             results_seen, o_out.payoff, o_out.notional, o_out.segment);
            end else begin
                want = awaited_payoffs.pop_front();
                if (o_out.payoff !== want.payoff || o_out.notional !== want.notional ||
                    o_out.segment !== want.segment) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result %0d: expected payoff %h notional %h segment %0d",
                               results_seen, want.payoff, want.notional, want.segment);
                        $display(", got payoff %h notional %h segment %0d",
                                 o_out.payoff, o_out.notional, o_out.segment);
                    end
                end
            end
        end
        if (in_fire) awaited_payoffs.push_back(payoff_for(i_in));
        if (i_rst_n && !in_fire && !out_fire) quiet_cycles++;
        else quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned pts_list [NUM_PHASES];
        logic [31:0] strike_val;
        pts_list = '{16, 1, 0, 31, 17, 5, 16, 2, 16, 9};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: a rounding tie in segment 0 and a full-range factor swing
        // across the linear segment from entry 3 to entry 4.
        for (int i = 0; i < NPTS; i++)
            queue_load(i, (i == 1) ? 32'd2 : i * 32'h0080_0000,
                       (i == 0) ? 32'h0001_8000 : (i == 1) ? 32'h0001_8001 :
                       (i == 3) ? 32'h8000_0000 : (i == 4) ? 32'h7FFF_FFFF : $urandom,
                       (i % 3 == 0) ? MODE_LINEAR : MODE_STAIRS);
        queue_eval(32'hFFFF_FFFF, 32'h8000_0000);
        queue_eval(32'h0003_0000, 32'h7FFF_FFFF);
        wait_drained();
        write_reg(CFG_POINTS, NPTS);
        queue_eval($urandom, 32'd1);
        queue_eval(32'hFFFF_FFFF, 32'h0198_0000);
        queue_eval(32'h0, 32'h0780_0000);
        queue_eval($urandom, 32'hFFFF_FFFF);
        queue_eval($urandom, 32'h0300_0000);
        queue_eval($urandom, 32'h0340_0000);
        wait_drained();
        write_reg(CFG_STRIKE, 32'hFFFF_FFFF);
        write_reg(CFG_IS_CALL, 32'h0);
        queue_eval(32'h0, 32'h0180_0000);
        queue_eval(32'h0, 32'h0200_0000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            idle_on = (ph % 4 != 3);
            case (ph % 4)
                0: strike_val = 32'h0;
                1: strike_val = 32'hFFFF_FFFF;
                2: strike_val = $urandom;
                default: strike_val = $urandom_range(32'h0080_0000);
            endcase
            write_reg(CFG_STRIKE, strike_val);
            write_reg(CFG_IS_CALL, ($urandom & ~32'h1) | (ph & 1));
            write_reg(CFG_POINTS, ($urandom & ~32'h1F) | pts_list[ph]);
            if (ph % 3 != 1) queue_sorted_table();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 5 && i == PHASE_ITEMS / 2) wait_drained();
                if ($urandom_range(99) < 15)
                    queue_load($urandom_range(NPTS - 1), $urandom, pick_factor(),
                               1'($urandom_range(1)));
                else
                    queue_eval(pick_spot(), pick_rate());
            end
            if (ph == 2) hold_requests++;
        end

        wait_drained();
        if (mismatches == 0 && awaited_payoffs.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
